FILE: design/stq_pkg.sv
// Shared types, codes and helpers for the sorted one-shot timer queue.
package stq_pkg;

   localparam int TIMER_SLOTS_DEFAULT = 16;

   localparam int FUNC_W = 2;
   localparam int ID_W   = 4;
   localparam int TIME_W = 32;
   localparam int TAG_W  = 16;

   // request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ARM  = 2'd0,
      FUNC_STOP = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   // what an incoming request turns into once decoded
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ARM,
      KIND_STOP,
      KIND_TICK
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARM_REMOVE,
      ST_ARM_INSERT,
      ST_STOP_REMOVE,
      ST_FIRE
   } state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_LOAD,
      DP_REMOVE,
      DP_INSERT,
      DP_POP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         head_due;
      logic         head_last;
      logic         out_free;
   } dp_status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] expiry;
      logic [TAG_W-1:0]  tag;
      logic              has_callback;
   } entry_type;

   // true when time a is not later than time b, by wrapped signed difference
   function automatic logic not_later(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return (diff == '0) || diff[TIME_W-1];
   endfunction

endpackage

FILE: design/stq_ifs.sv
// Request and response channel interfaces of the timer queue.
interface stq_req_if;
   import stq_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   timer_id;
   logic [TIME_W-1:0] delay;
   logic [TIME_W-1:0] now;
   logic              has_callback;
   logic [TAG_W-1:0]  callback_tag;

   modport source (output valid, func, timer_id, delay, now, has_callback, callback_tag,
                   input ready);
   modport sink (input valid, func, timer_id, delay, now, has_callback, callback_tag,
                 output ready);
endinterface

interface stq_rsp_if;
   import stq_pkg::*;

   logic             valid;
   logic             ready;
   logic [ID_W-1:0]  fired_id;
   logic [TAG_W-1:0] fired_tag;
   logic             fired_has_callback;
   logic             last_fired;

   modport source (output valid, fired_id, fired_tag, fired_has_callback, last_fired,
                   input ready);
   modport sink (input valid, fired_id, fired_tag, fired_has_callback, last_fired,
                 output ready);
endinterface

FILE: design/sorted_oneshot_timer_queue_core.sv
// Top level of the sorted one-shot timer queue.
//
// Usage:
//   req_bus carries one request per valid/ready handshake: arm (func 0) sets
//   timer_id to expire at now + delay with its tag and callback flag, stop
//   (func 1) cancels timer_id, tick (func 2) fires every timer due at now.
//   rsp_bus returns one response per fired timer in expiry order; last_fired
//   marks the final one of a tick. Arm and stop return nothing.
// Steps:
//   arm runs accept, removal of the old copy and sorted insert; stop runs
//   accept and removal; tick runs accept, then one pop per fired timer, and a
//   tick with nothing due still passes the fire check. All steps run on the
//   shift array, so a new request is taken once the current one is done.
// Reset clears every slot's valid bit; the queue is usable once reset is
//   released. When the receiver stalls, the response register holds its
//   response and firing pauses; requests are still accepted while the last
//   response of a tick waits to be taken.
module sorted_oneshot_timer_queue_core #(
   parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   stq_req_if.sink  req_bus,
   stq_rsp_if.source rsp_bus
);
   import stq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: owns the request handshake and steps the datapath
   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot array, request latch and response register
   stq_datapath #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_func               (req_bus.func),
      .req_timer_id           (req_bus.timer_id),
      .req_delay              (req_bus.delay),
      .req_now                (req_bus.now),
      .req_has_callback       (req_bus.has_callback),
      .req_callback_tag       (req_bus.callback_tag),
      .rsp_ready              (rsp_bus.ready),
      .rsp_valid              (rsp_bus.valid),
      .rsp_fired_id           (rsp_bus.fired_id),
      .rsp_fired_tag          (rsp_bus.fired_tag),
      .rsp_fired_has_callback (rsp_bus.fired_has_callback),
      .rsp_last_fired         (rsp_bus.last_fired)
   );

endmodule

FILE: design/stq_ctrl.sv
// Sequencer of the timer queue: accepts requests and issues datapath steps.
module stq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  stq_pkg::dp_status_type status,
   output stq_pkg::dp_cmd_type    cmd
);
   import stq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (status.req_kind)
                  KIND_ARM:  state_in = ST_ARM_REMOVE;
                  KIND_STOP: state_in = ST_STOP_REMOVE;
                  KIND_TICK: state_in = ST_FIRE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ARM_REMOVE:  state_in = ST_ARM_INSERT;
         ST_ARM_INSERT:  state_in = ST_IDLE;
         ST_STOP_REMOVE: state_in = ST_IDLE;
         ST_FIRE: begin
            if (!status.head_due) begin
               state_in = ST_IDLE;
            end else if (status.out_free && status.head_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = DP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_LOAD;
            end
         end
         ST_ARM_REMOVE:  cmd.op = DP_REMOVE;
         ST_STOP_REMOVE: cmd.op = DP_REMOVE;
         ST_ARM_INSERT:  cmd.op = DP_INSERT;
         ST_FIRE: begin
            if (status.head_due && status.out_free) begin
               cmd.op = DP_POP;
            end
         end
         default: cmd.op = DP_NONE;
      endcase
   end

endmodule

FILE: design/stq_datapath.sv
// Datapath of the timer queue: sorted slot array, request latch and response register.
module stq_datapath #(
   parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  stq_pkg::dp_cmd_type         cmd,
   output stq_pkg::dp_status_type      status,
   input  logic [stq_pkg::FUNC_W-1:0]  req_func,
   input  logic [stq_pkg::ID_W-1:0]    req_timer_id,
   input  logic [stq_pkg::TIME_W-1:0]  req_delay,
   input  logic [stq_pkg::TIME_W-1:0]  req_now,
   input  logic                        req_has_callback,
   input  logic [stq_pkg::TAG_W-1:0]   req_callback_tag,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [stq_pkg::ID_W-1:0]    rsp_fired_id,
   output logic [stq_pkg::TAG_W-1:0]   rsp_fired_tag,
   output logic                        rsp_fired_has_callback,
   output logic                        rsp_last_fired
);
   import stq_pkg::*;

   function automatic logic [TIMER_SLOTS-1:0] below_mask(input int idx);
      return {TIMER_SLOTS{1'b1}} >> (TIMER_SLOTS - idx);
   endfunction

   function automatic logic [TIMER_SLOTS-1:0] upto_mask(input int idx);
      return {TIMER_SLOTS{1'b1}} >> (TIMER_SLOTS - 1 - idx);
   endfunction

   // latched request
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] expiry_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              cb_ff;

   // sorted slots, valid bits form a prefix
   entry_type              entry_ff [TIMER_SLOTS];
   entry_type              entry_in [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] valid_ff;
   logic [TIMER_SLOTS-1:0] valid_in;

   entry_type              up_entry [TIMER_SLOTS];
   logic                   up_valid [TIMER_SLOTS];
   entry_type              dn_entry [TIMER_SLOTS];
   logic                   dn_valid [TIMER_SLOTS];
   entry_type              new_entry;

   logic [TIMER_SLOTS-1:0] match_vec;
   logic [TIMER_SLOTS-1:0] stop_vec;
   logic                   full;
   logic                   id_ok;
   req_kind_type           req_kind;
   logic [TIME_W-1:0]      diff0;
   logic [TIME_W-1:0]      diff1;
   logic                   due0;
   logic                   due1;

   logic                   rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) begin
         id_ff     <= req_timer_id;
         expiry_ff <= req_now + req_delay;
         now_ff    <= req_now;
         tag_ff    <= req_callback_tag;
         cb_ff     <= req_has_callback;
      end
   end

   assign new_entry = '{id: id_ff, expiry: expiry_ff, tag: tag_ff, has_callback: cb_ff};

   // neighbor taps for shifting toward the head and away from it
   for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_tap
      if (i < TIMER_SLOTS - 1) begin : g_up
         assign up_entry[i] = entry_ff[i+1];
         assign up_valid[i] = valid_ff[i+1];
      end else begin : g_up_end
         assign up_entry[i] = entry_ff[i];
         assign up_valid[i] = 1'b0;
      end
      if (i > 0) begin : g_dn
         assign dn_entry[i] = entry_ff[i-1];
         assign dn_valid[i] = valid_ff[i-1];
      end else begin : g_dn_end
         assign dn_entry[i] = new_entry;
         assign dn_valid[i] = 1'b1;
      end
   end

   // decode the live request
   assign id_ok = int'(req_timer_id) < TIMER_SLOTS;

   always_comb begin
      case (req_func)
         FUNC_ARM:  req_kind = id_ok ? KIND_ARM : KIND_NONE;
         FUNC_STOP: req_kind = id_ok ? KIND_STOP : KIND_NONE;
         FUNC_TICK: req_kind = KIND_TICK;
         default:   req_kind = KIND_NONE;
      endcase
   end

   assign status.req_kind = req_kind;

   // per-slot compares
   always_comb begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         match_vec[i] = valid_ff[i] && (entry_ff[i].id == id_ff);
         stop_vec[i]  = !(valid_ff[i] && not_later(entry_ff[i].expiry, expiry_ff));
      end
   end

   assign full  = valid_ff[TIMER_SLOTS-1];
   assign diff0 = now_ff - entry_ff[0].expiry;
   assign diff1 = now_ff - entry_ff[1].expiry;
   assign due0  = valid_ff[0] && !diff0[TIME_W-1];
   assign due1  = valid_ff[1] && !diff1[TIME_W-1];

   assign status.head_due  = due0;
   assign status.head_last = !due1;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // slot update: remove closes the gap, insert opens one unless full, pop advances all
   always_comb begin
      logic rm_shift;
      logic ins_before;
      logic ins_here;
      entry_in = entry_ff;
      valid_in = valid_ff;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         rm_shift   = |(match_vec & upto_mask(i));
         ins_before = |(stop_vec & below_mask(i));
         ins_here   = stop_vec[i] && !ins_before;
         case (cmd.op)
            DP_REMOVE: begin
               if (rm_shift) begin
                  entry_in[i] = up_entry[i];
                  valid_in[i] = up_valid[i];
               end
            end
            DP_INSERT: begin
               if (!full) begin
                  if (ins_before) begin
                     entry_in[i] = dn_entry[i];
                     valid_in[i] = dn_valid[i];
                  end else if (ins_here) begin
                     entry_in[i] = new_entry;
                     valid_in[i] = 1'b1;
                  end
               end
            end
            DP_POP: begin
               entry_in[i] = up_entry[i];
               valid_in[i] = up_valid[i];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == DP_POP) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_POP) begin
         rsp_fired_id           <= entry_ff[0].id;
         rsp_fired_tag          <= entry_ff[0].tag;
         rsp_fired_has_callback <= entry_ff[0].has_callback;
         rsp_last_fired         <= !due1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_ff + {{(TIMER_SLOTS-1){1'b0}}, 1'b1}) & valid_ff) == '0)
      else $error("slot valid bits are not a prefix");

   a_unique_id: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_REMOVE |-> $onehot0(match_vec))
      else $error("timer id queued more than once");

   a_pop_due: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_POP |-> due0 && (!rsp_valid_ff || rsp_ready))
      else $error("pop without a due head or a free response register");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_INSERT && !full |=>
         $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("insert did not add exactly one slot");
`endif

endmodule
